>>> design/scat_pkg.sv
// Shared types, constants and helpers for the sprite cull and transform unit.
// No dependencies; every other file but the sprite and result interfaces uses it.
`timescale 1ns / 1ps
`default_nettype none

package scat_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STAGES = 32;

  localparam logic [15:0] ALPHA_ONE = 16'd32768;
  localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

  localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
  localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM     = 3'd0,
    REG_CAM_X    = 3'd1,
    REG_CAM_Y    = 3'd2,
    REG_CVEL_X   = 3'd3,
    REG_CVEL_Y   = 3'd4,
    REG_HALF_W   = 3'd5,
    REG_HALF_H   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        zoom;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cvel_x;
    logic signed [31:0] cvel_y;
    logic [13:0]        half_w;
    logic [13:0]        half_h;
  } cfg_t;

  // Classified sprite as it waits between the front and back halves.
  typedef struct packed {
    logic               culled;
    logic signed [37:0] px;
    logic signed [37:0] py;
    logic signed [32:0] bx;
    logic signed [32:0] by;
    logic signed [32:0] uxh;
    logic signed [32:0] uyw;
    logic signed [32:0] uxw;
    logic signed [32:0] uyh;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        cloak;
  } entry_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    begin
      if (x > LIM_HI) begin
        r = SAT_MAX;
      end else if (x < LIM_LO) begin
        r = SAT_MIN;
      end else begin
        r = x[31:0];
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/scat_sprite_if.sv
// Sprite input channel: valid/ready handshake plus one sprite's fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface scat_sprite_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [15:0]        parallax;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic [15:0]        sprite_width;
  logic [15:0]        sprite_height;
  logic               drawable;
  logic [15:0]        cloak;
  logic               blur_enable;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, parallax, unit_x, unit_y,
                  sprite_width, sprite_height, drawable, cloak, blur_enable,
                  input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, parallax, unit_x, unit_y,
                sprite_width, sprite_height, drawable, cloak, blur_enable,
                output ready);
endinterface

`default_nettype wire

>>> design/scat_result_if.sv
// Result output channel: valid/ready handshake plus one transformed sprite.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface scat_result_if;
  logic               valid;
  logic               ready;
  logic               culled;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] xform_a;
  logic signed [31:0] xform_b;
  logic signed [31:0] xform_c;
  logic signed [31:0] xform_d;
  logic signed [31:0] blur_u;
  logic signed [31:0] blur_v;
  logic [15:0]        alpha;

  modport source (output valid, culled, screen_x, screen_y, xform_a, xform_b, xform_c,
                  xform_d, blur_u, blur_v, alpha, input ready);
  modport sink (input valid, culled, screen_x, screen_y, xform_a, xform_b, xform_c,
                xform_d, blur_u, blur_v, alpha, output ready);
endinterface

`default_nettype wire

>>> design/scat_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on scat_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface scat_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [scat_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/scat_front.sv
// Front half: accepts sprites, applies parallax and blur, decides the cull.
// Depends on scat_pkg and scat_sprite_if; five register stages.
`timescale 1ns / 1ps
`default_nettype none

module scat_front (
  input  logic           clk,
  input  logic           rst,
  input  scat_pkg::cfg_t cfg,
  scat_sprite_if.sink    sprite,
  output scat_pkg::entry_t entry,
  output logic           entry_valid,
  input  logic           entry_ready
);
  import scat_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [48:0] cpx;
    logic signed [48:0] cpy;
    logic signed [32:0] bx;
    logic signed [32:0] by;
    logic signed [32:0] uxh;
    logic signed [32:0] uyw;
    logic signed [32:0] uxw;
    logic signed [32:0] uyh;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        cloak;
    logic               drawable;
  } st1_t;

  typedef struct packed {
    entry_t      e;
    logic [40:0] sx;
    logic [40:0] sy;
  } st2_t;

  typedef struct packed {
    entry_t             e;
    logic signed [46:0] hx;
    logic signed [46:0] lx;
    logic signed [46:0] hy;
    logic signed [46:0] ly;
  } st3_t;

  typedef struct packed {
    entry_t             e;
    logic signed [63:0] mhx;
    logic signed [63:0] mlx;
    logic signed [63:0] mhy;
    logic signed [63:0] mly;
  } st4_t;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  entry_t entry_next;
  logic [4:0] vld;
  logic adv;

  logic [32:0] a_uxh, a_uyw, a_uxw, a_uyh, a_bx, a_by;
  logic signed [63:0] lim_x, lim_y, nlim_x, nlim_y;

  assign adv          = !vld[4] || entry_ready;
  assign sprite.ready = adv;
  assign entry_valid  = vld[4];

  always_comb begin
    s1_next.pos_x    = sprite.pos_x;
    s1_next.pos_y    = sprite.pos_y;
    s1_next.cpx      = $signed(cfg.cam_x) * $signed({1'b0, sprite.parallax});
    s1_next.cpy      = $signed(cfg.cam_y) * $signed({1'b0, sprite.parallax});
    s1_next.bx       = sprite.blur_enable ?
                       ($signed(sprite.vel_x) - $signed(cfg.cvel_x)) : 33'sd0;
    s1_next.by       = sprite.blur_enable ?
                       ($signed(sprite.vel_y) - $signed(cfg.cvel_y)) : 33'sd0;
    s1_next.uxh      = $signed(sprite.unit_x) * $signed({1'b0, sprite.sprite_height});
    s1_next.uyw      = $signed(sprite.unit_y) * $signed({1'b0, sprite.sprite_width});
    s1_next.uxw      = $signed(sprite.unit_x) * $signed({1'b0, sprite.sprite_width});
    s1_next.uyh      = $signed(sprite.unit_y) * $signed({1'b0, sprite.sprite_height});
    s1_next.ux       = sprite.unit_x;
    s1_next.uy       = sprite.unit_y;
    s1_next.w        = sprite.sprite_width;
    s1_next.h        = sprite.sprite_height;
    s1_next.cloak    = sprite.cloak;
    s1_next.drawable = sprite.drawable;
  end

  // Half extents of the rotated box plus blur, doubled, in Q.18.
  always_comb begin
    a_uxh = s1.uxh[32] ? -$signed(s1.uxh) : $signed(s1.uxh);
    a_uyw = s1.uyw[32] ? -$signed(s1.uyw) : $signed(s1.uyw);
    a_uxw = s1.uxw[32] ? -$signed(s1.uxw) : $signed(s1.uxw);
    a_uyh = s1.uyh[32] ? -$signed(s1.uyh) : $signed(s1.uyh);
    a_bx  = s1.bx[32] ? -$signed(s1.bx) : $signed(s1.bx);
    a_by  = s1.by[32] ? -$signed(s1.by) : $signed(s1.by);

    s2_next.e.culled = !s1.drawable;
    s2_next.e.px     = $signed(s1.pos_x) - $signed(s1.cpx[48:12]);
    s2_next.e.py     = $signed(s1.pos_y) - $signed(s1.cpy[48:12]);
    s2_next.e.bx     = s1.bx;
    s2_next.e.by     = s1.by;
    s2_next.e.uxh    = s1.uxh;
    s2_next.e.uyw    = s1.uyw;
    s2_next.e.uxw    = s1.uxw;
    s2_next.e.uyh    = s1.uyh;
    s2_next.e.ux     = s1.ux;
    s2_next.e.uy     = s1.uy;
    s2_next.e.w      = s1.w;
    s2_next.e.h      = s1.h;
    s2_next.e.cloak  = s1.cloak;
    s2_next.sx       = {8'b0, a_uxh} + {8'b0, a_uyw} + {2'b0, a_bx, 6'b0};
    s2_next.sy       = {8'b0, a_uxw} + {8'b0, a_uyh} + {2'b0, a_by, 6'b0};
  end

  always_comb begin
    s3_next.e  = s2.e;
    s3_next.hx = $signed({s2.e.px, 7'b0}) + $signed({1'b0, s2.sx});
    s3_next.lx = $signed({s2.e.px, 7'b0}) - $signed({1'b0, s2.sx});
    s3_next.hy = $signed({s2.e.py, 7'b0}) + $signed({1'b0, s2.sy});
    s3_next.ly = $signed({s2.e.py, 7'b0}) - $signed({1'b0, s2.sy});
  end

  always_comb begin
    s4_next.e   = s3.e;
    s4_next.mhx = $signed(s3.hx) * $signed({1'b0, cfg.zoom});
    s4_next.mlx = $signed(s3.lx) * $signed({1'b0, cfg.zoom});
    s4_next.mhy = $signed(s3.hy) * $signed({1'b0, cfg.zoom});
    s4_next.mly = $signed(s3.ly) * $signed({1'b0, cfg.zoom});
  end

  // Screen edges doubled into Q.30 to match the scaled box.
  assign lim_x  = $signed({19'b0, cfg.half_w, 31'b0});
  assign lim_y  = $signed({19'b0, cfg.half_h, 31'b0});
  assign nlim_x = -lim_x;
  assign nlim_y = -lim_y;

  always_comb begin
    entry_next        = s4.e;
    entry_next.culled = s4.e.culled ||
                        ($signed(s4.mhx) < nlim_x) || ($signed(s4.mhy) < nlim_y) ||
                        ($signed(s4.mlx) > lim_x)  || ($signed(s4.mly) > lim_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], sprite.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      s4    <= s4_next;
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

>>> design/scat_fifo.sv
// Short queue between the front and back halves; holds classified sprites.
// Depends on scat_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module scat_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  scat_pkg::entry_t in_data,
  input  logic             in_valid,
  output logic             in_ready,
  output scat_pkg::entry_t out_data,
  output logic             out_valid,
  input  logic             out_ready
);
  import scat_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic push, pop, full;

  assign full      = (count == CW'(DEPTH));
  assign in_ready  = !full;
  assign out_valid = (count != '0);
  assign push      = in_valid && !full;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count missed a push");

  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> (wp == rp))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> design/scat_div.sv
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Depends on scat_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module scat_div (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] num,
  input  logic [15:0] den,
  output logic [31:0] quo
);
  import scat_pkg::*;

  logic [15:0] rem [DIV_STAGES];
  logic [31:0] work [DIV_STAGES];
  logic [15:0] dq [DIV_STAGES];
  logic [15:0] rem_next [DIV_STAGES];
  logic [31:0] work_next [DIV_STAGES];
  logic [15:0] dq_next [DIV_STAGES];

  // The upper numerator bits seed the remainder; the caller flags
  // quotients that need more than 32 bits.
  always_comb begin
    logic [15:0] r_in;
    logic [31:0] w_in;
    logic [15:0] d_in;
    logic [16:0] t;
    logic        ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        r_in = num[47:32];
        w_in = num[31:0];
        d_in = den;
      end else begin
        r_in = rem[i-1];
        w_in = work[i-1];
        d_in = dq[i-1];
      end
      t            = {r_in, w_in[31]};
      ge           = (t >= {1'b0, d_in});
      rem_next[i]  = ge ? 16'(t - {1'b0, d_in}) : t[15:0];
      work_next[i] = {w_in[30:0], ge};
      dq_next[i]   = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem[i]  <= rem_next[i];
        work[i] <= work_next[i];
        dq[i]   <= dq_next[i];
      end
    end
  end

  assign quo = work[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> design/scat_back.sv
// Back half: zoom, transform, blur projection and blur division per sprite.
// Depends on scat_pkg, scat_div and scat_result_if.
`timescale 1ns / 1ps
`default_nettype none

module scat_back (
  input  logic             clk,
  input  logic             rst,
  input  scat_pkg::cfg_t   cfg,
  input  scat_pkg::entry_t entry,
  input  logic             entry_valid,
  output logic             entry_ready,
  scat_result_if.source    result
);
  import scat_pkg::*;

  localparam int NV = 5 + DIV_STAGES;

  typedef struct packed {
    logic        culled;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] xa;
    logic [31:0] xb;
    logic [31:0] xc;
    logic [31:0] xd;
    logic [15:0] alpha;
  } res_t;

  typedef struct packed {
    logic               culled;
    logic signed [54:0] pzx;
    logic signed [54:0] pzy;
    logic signed [49:0] tza;
    logic signed [49:0] tzb;
    logic signed [49:0] tzc;
    logic signed [49:0] tzd;
    logic signed [49:0] bzrx;
    logic signed [49:0] bzry;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        cloak;
  } bt1_t;

  typedef struct packed {
    res_t               r;
    logic signed [37:0] bzx;
    logic signed [37:0] bzy;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic [15:0]        w;
    logic [15:0]        h;
  } bt2_t;

  typedef struct packed {
    res_t               r;
    logic signed [53:0] m1;
    logic signed [53:0] m2;
    logic signed [53:0] m3;
    logic signed [53:0] m4;
    logic [15:0]        w;
    logic [15:0]        h;
  } bt3_t;

  typedef struct packed {
    res_t               r;
    logic signed [55:0] cu;
    logic signed [55:0] dn;
    logic [15:0]        w;
    logic [15:0]        h;
  } bt4_t;

  typedef struct packed {
    res_t        r;
    logic [55:0] mag_u;
    logic [55:0] mag_v;
    logic        neg_u;
    logic        neg_v;
    logic        zero_u;
    logic        zero_v;
    logic [15:0] w;
    logic [15:0] h;
  } bt5_t;

  typedef struct packed {
    res_t r;
    logic neg_u;
    logic ovf_u;
    logic zero_u;
    logic neg_v;
    logic ovf_v;
    logic zero_v;
  } side_t;

  typedef struct packed {
    logic        culled;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] xa;
    logic [31:0] xb;
    logic [31:0] xc;
    logic [31:0] xd;
    logic [31:0] blur_u;
    logic [31:0] blur_v;
    logic [15:0] alpha;
  } out_t;

  bt1_t b1, b1_next;
  bt2_t b2, b2_next;
  bt3_t b3, b3_next;
  bt4_t b4, b4_next;
  bt5_t b5, b5_next;
  side_t side_next;
  side_t sd [DIV_STAGES];
  out_t res, res_next;
  logic [NV-1:0] vld;
  logic res_valid;
  logic en;
  logic [31:0] q_u, q_v;
  logic signed [50:0] na, nc, nd;

  function automatic logic [31:0] blur_fmt(input logic [31:0] q, input logic neg,
                                           input logic ovf, input logic zero);
    logic [31:0] r;
    begin
      if (zero) begin
        r = '0;
      end else if (ovf) begin
        r = neg ? SAT_MIN : SAT_MAX;
      end else if (neg) begin
        r = (q[31] && (q[30:0] != '0)) ? SAT_MIN : -q;
      end else begin
        r = q[31] ? SAT_MAX : q;
      end
      return r;
    end
  endfunction

  assign en          = !res_valid || result.ready;
  assign entry_ready = en;

  always_comb begin
    b1_next.culled = entry.culled;
    b1_next.pzx    = $signed(entry.px) * $signed({1'b0, cfg.zoom});
    b1_next.pzy    = $signed(entry.py) * $signed({1'b0, cfg.zoom});
    b1_next.tza    = $signed(entry.uyw) * $signed({1'b0, cfg.zoom});
    b1_next.tzb    = $signed(entry.uxw) * $signed({1'b0, cfg.zoom});
    b1_next.tzc    = $signed(entry.uxh) * $signed({1'b0, cfg.zoom});
    b1_next.tzd    = $signed(entry.uyh) * $signed({1'b0, cfg.zoom});
    b1_next.bzrx   = $signed(entry.bx) * $signed({1'b0, cfg.zoom});
    b1_next.bzry   = $signed(entry.by) * $signed({1'b0, cfg.zoom});
    b1_next.ux     = entry.ux;
    b1_next.uy     = entry.uy;
    b1_next.w      = entry.w;
    b1_next.h      = entry.h;
    b1_next.cloak  = entry.cloak;
  end

  // Negate before the floor shift so the rounding direction follows the sign.
  assign na = -51'($signed(b1.tza));
  assign nc = -51'($signed(b1.tzc));
  assign nd = -51'($signed(b1.tzd));

  always_comb begin
    b2_next.r.culled   = b1.culled;
    b2_next.r.screen_x = sat32(64'($signed(b1.pzx[54:12])));
    b2_next.r.screen_y = sat32(64'($signed(b1.pzy[54:12])));
    b2_next.r.xa       = sat32(64'($signed(na[50:18])));
    b2_next.r.xb       = sat32(64'($signed(b1.tzb[49:18])));
    b2_next.r.xc       = sat32(64'($signed(nc[50:18])));
    b2_next.r.xd       = sat32(64'($signed(nd[50:18])));
    b2_next.r.alpha    = (b1.cloak >= ALPHA_ONE) ? 16'd0 : ALPHA_ONE - b1.cloak;
    b2_next.bzx        = $signed(b1.bzrx[49:12]);
    b2_next.bzy        = $signed(b1.bzry[49:12]);
    b2_next.ux         = b1.ux;
    b2_next.uy         = b1.uy;
    b2_next.w          = b1.w;
    b2_next.h          = b1.h;
  end

  always_comb begin
    b3_next.r  = b2.r;
    b3_next.m1 = $signed(b2.ux) * $signed(b2.bzy);
    b3_next.m2 = $signed(b2.uy) * $signed(b2.bzx);
    b3_next.m3 = $signed(b2.ux) * $signed(b2.bzx);
    b3_next.m4 = $signed(b2.uy) * $signed(b2.bzy);
    b3_next.w  = b2.w;
    b3_next.h  = b2.h;
  end

  always_comb begin
    b4_next.r  = b3.r;
    b4_next.cu = 56'($signed(b3.m1)) - 56'($signed(b3.m2));
    b4_next.dn = -(56'($signed(b3.m3)) + 56'($signed(b3.m4)));
    b4_next.w  = b3.w;
    b4_next.h  = b3.h;
  end

  always_comb begin
    b5_next.r      = b4.r;
    b5_next.neg_u  = b4.cu[55];
    b5_next.neg_v  = b4.dn[55];
    b5_next.mag_u  = b4.cu[55] ? -b4.cu : b4.cu;
    b5_next.mag_v  = b4.dn[55] ? -b4.dn : b4.dn;
    b5_next.zero_u = (b4.cu == '0);
    b5_next.zero_v = (b4.dn == '0);
    b5_next.w      = b4.w;
    b5_next.h      = b4.h;
  end

  // Divide |num|/64 by the raw size; a top part at or above the divisor
  // means the quotient needs more than 32 bits (or the size is zero).
  always_comb begin
    side_next.r      = b5.r;
    side_next.neg_u  = b5.neg_u;
    side_next.zero_u = b5.zero_u;
    side_next.ovf_u  = (b5.mag_u[55:38] >= {2'b0, b5.w});
    side_next.neg_v  = b5.neg_v;
    side_next.zero_v = b5.zero_v;
    side_next.ovf_v  = (b5.mag_v[55:38] >= {2'b0, b5.h});
  end

  scat_div u_div_u (
    .clk (clk),
    .en  (en),
    .num (b5.mag_u[53:6]),
    .den (b5.w),
    .quo (q_u)
  );

  scat_div u_div_v (
    .clk (clk),
    .en  (en),
    .num (b5.mag_v[53:6]),
    .den (b5.h),
    .quo (q_v)
  );

  always_comb begin
    res_next.culled = sd[DIV_STAGES-1].r.culled;
    if (sd[DIV_STAGES-1].r.culled) begin
      res_next.screen_x = '0;
      res_next.screen_y = '0;
      res_next.xa       = '0;
      res_next.xb       = '0;
      res_next.xc       = '0;
      res_next.xd       = '0;
      res_next.blur_u   = '0;
      res_next.blur_v   = '0;
      res_next.alpha    = '0;
    end else begin
      res_next.screen_x = sd[DIV_STAGES-1].r.screen_x;
      res_next.screen_y = sd[DIV_STAGES-1].r.screen_y;
      res_next.xa       = sd[DIV_STAGES-1].r.xa;
      res_next.xb       = sd[DIV_STAGES-1].r.xb;
      res_next.xc       = sd[DIV_STAGES-1].r.xc;
      res_next.xd       = sd[DIV_STAGES-1].r.xd;
      res_next.blur_u   = blur_fmt(q_u, sd[DIV_STAGES-1].neg_u, sd[DIV_STAGES-1].ovf_u,
                                   sd[DIV_STAGES-1].zero_u);
      res_next.blur_v   = blur_fmt(q_v, sd[DIV_STAGES-1].neg_v, sd[DIV_STAGES-1].ovf_v,
                                   sd[DIV_STAGES-1].zero_v);
      res_next.alpha    = sd[DIV_STAGES-1].r.alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NV-2:0], entry_valid};
      res_valid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1    <= b1_next;
      b2    <= b2_next;
      b3    <= b3_next;
      b4    <= b4_next;
      b5    <= b5_next;
      sd[0] <= side_next;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sd[i] <= sd[i-1];
      end
      res   <= res_next;
    end
  end

  assign result.valid    = res_valid;
  assign result.culled   = res.culled;
  assign result.screen_x = res.screen_x;
  assign result.screen_y = res.screen_y;
  assign result.xform_a  = res.xa;
  assign result.xform_b  = res.xb;
  assign result.xform_c  = res.xc;
  assign result.xform_d  = res.xd;
  assign result.blur_u   = res.blur_u;
  assign result.blur_v   = res.blur_v;
  assign result.alpha    = res.alpha;

  a_culled_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.culled) |-> (res.screen_x == '0 && res.blur_u == '0 &&
                                   res.blur_v == '0 && res.alpha == '0))
    else $error("culled result carries nonzero fields");

endmodule

`default_nettype wire

>>> design/sprite_cull_and_transform_unit.sv
// Top level of the sprite cull and transform unit: config registers,
// front half, queue and back half. Depends on scat_pkg and all scat_* files.
//
//   channel  | role   | moves per transaction
//   ---------+--------+---------------------------------------------------
//   sprite   | sink   | one sprite: position, velocity, parallax, facing,
//            |        | size, drawable, cloak, blur enable
//   result   | source | culled flag, screen position, 2x2 transform,
//            |        | blur in texture units, alpha
//   cfg      | sink   | register index and 32-bit write data
//
// One sprite per cycle sustained while result is not stalled; every sprite
// gives one result. With the queue empty a sprite passes 5 front stages,
// the queue, 5 back stages, 32 divider stages (one quotient bit each) and
// the output register. The back stalls only when a result is held on result;
// the queue and the five front stages then absorb up to QUEUE_DEPTH + 5
// sprites before sprite ready drops. Reset is synchronous and restores
// register defaults. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sprite_cull_and_transform_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  scat_sprite_if.sink   sprite,
  scat_result_if.source result,
  scat_cfg_if.sink      cfg
);
  import scat_pkg::*;

  cfg_t   regs;
  entry_t f_entry, q_entry;
  logic   f_valid, f_ready, q_valid, q_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.zoom   <= 16'd4096;
      regs.cam_x  <= '0;
      regs.cam_y  <= '0;
      regs.cvel_x <= '0;
      regs.cvel_y <= '0;
      regs.half_w <= 14'd960;
      regs.half_h <= 14'd540;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ZOOM:   regs.zoom   <= cfg.data[15:0];
        REG_CAM_X:  regs.cam_x  <= cfg.data;
        REG_CAM_Y:  regs.cam_y  <= cfg.data;
        REG_CVEL_X: regs.cvel_x <= cfg.data;
        REG_CVEL_Y: regs.cvel_y <= cfg.data;
        REG_HALF_W: regs.half_w <= cfg.data[13:0];
        REG_HALF_H: regs.half_h <= cfg.data[13:0];
        default: ;
      endcase
    end
  end

  scat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .sprite      (sprite),
    .entry       (f_entry),
    .entry_valid (f_valid),
    .entry_ready (f_ready)
  );

  scat_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_entry),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (q_entry),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  scat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .entry       (q_entry),
    .entry_valid (q_valid),
    .entry_ready (q_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

>>> dv/tb_sprite_cull_and_transform_unit.sv
// Self-checking testbench for the sprite cull and transform unit.
// Drives random and directed sprites through the sprite channel and checks
// every result against a behavioral predictor. Depends on scat_pkg and scat_*_if.
`timescale 1ns / 1ps

module tb_sprite_cull_and_transform_unit;
  import scat_pkg::*;

  localparam int LATENCY   = 44;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1100;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [15:0]        parallax;
    logic signed [15:0] unit_x, unit_y;
    logic [15:0]        w, h;
    logic               drawable;
    logic [15:0]        cloak;
    logic               blur_en;
  } sprite_t;

  typedef struct {
    logic        culled;
    logic [31:0] sx, sy, xa, xb, xc, xd, bu, bv;
    logic [15:0] alpha;
  } xform_res_t;

  logic clk = 0;
  logic rst = 1;

  scat_sprite_if sprite_ch();
  scat_result_if result_ch();
  scat_cfg_if    cfg_ch();

  sprite_cull_and_transform_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .sprite (sprite_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // Predictor copy of the view registers
  logic [15:0]        zoom_q;
  longint             cam_x_q, cam_y_q, cvel_x_q, cvel_y_q, half_w_q, half_h_q;

  sprite_t    pending_sprites[$];
  xform_res_t expected_results[$];
  int         n_errors = 0;
  int         wdog = 0;
  bit         idle_on = 1;
  int         src_gap = 0;
  int         snk_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_sh(longint x, int k);
    return x >>> k;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint tex_div(longint num, longint size);
    if (size == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    return num / (64 * size);
  endfunction

  function automatic xform_res_t predict_sprite(sprite_t s);
    xform_res_t r;
    longint px, py, bx, by, ux, uy, w, h, z, sx, sy, ex, ey, bzx, bzy, cr, dt;
    r = '{default: '0};
    z  = zoom_q;
    ux = s.unit_x;
    uy = s.unit_y;
    w  = s.w;
    h  = s.h;
    px = longint'(s.pos_x) - floor_sh(cam_x_q * longint'(s.parallax), 12);
    py = longint'(s.pos_y) - floor_sh(cam_y_q * longint'(s.parallax), 12);
    bx = 0;
    by = 0;
    if (s.blur_en) begin
      bx = longint'(s.vel_x) - cvel_x_q;
      by = longint'(s.vel_y) - cvel_y_q;
    end
    r.culled = 1'b1;
    if (!s.drawable) return r;
    sx = mag(ux * h) + mag(uy * w) + mag(bx) * 64;
    sy = mag(ux * w) + mag(uy * h) + mag(by) * 64;
    ex = half_w_q * (64'sd1 << 31);
    ey = half_h_q * (64'sd1 << 31);
    if ((128 * px + sx) * z < -ex || (128 * py + sy) * z < -ey ||
        (128 * px - sx) * z > ex || (128 * py - sy) * z > ey) return r;
    r.culled = 1'b0;
    r.sx = clamp32(floor_sh(px * z, 12));
    r.sy = clamp32(floor_sh(py * z, 12));
    r.xa = clamp32(floor_sh(-(uy * w * z), 18));
    r.xb = clamp32(floor_sh(ux * w * z, 18));
    r.xc = clamp32(floor_sh(-(ux * h * z), 18));
    r.xd = clamp32(floor_sh(-(uy * h * z), 18));
    bzx = floor_sh(bx * z, 12);
    bzy = floor_sh(by * z, 12);
    cr  = ux * bzy - uy * bzx;
    dt  = ux * bzx + uy * bzy;
    r.bu = clamp32(tex_div(cr, w));
    r.bv = clamp32(tex_div(-dt, h));
    r.alpha = (s.cloak >= 16'd32768) ? 16'd0 : 16'd32768 - s.cloak;
    return r;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      sprite_ch.valid <= 1'b0;
    end else begin
      if (sprite_ch.valid && sprite_ch.ready) begin
        expected_results = {expected_results, predict_sprite('{sprite_ch.pos_x,
          sprite_ch.pos_y, sprite_ch.vel_x, sprite_ch.vel_y, sprite_ch.parallax,
          sprite_ch.unit_x, sprite_ch.unit_y, sprite_ch.sprite_width,
          sprite_ch.sprite_height, sprite_ch.drawable, sprite_ch.cloak,
          sprite_ch.blur_enable})};
      end
      if (!sprite_ch.valid || sprite_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          sprite_ch.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(1, 13) - 1;
          sprite_ch.valid <= 1'b0;
        end else if (pending_sprites.size() > 0) begin
          sprite_t s;
          s = pending_sprites.pop_front();
          sprite_ch.valid         <= 1'b1;
          sprite_ch.pos_x         <= s.pos_x;
          sprite_ch.pos_y         <= s.pos_y;
          sprite_ch.vel_x         <= s.vel_x;
          sprite_ch.vel_y         <= s.vel_y;
          sprite_ch.parallax      <= s.parallax;
          sprite_ch.unit_x        <= s.unit_x;
          sprite_ch.unit_y        <= s.unit_y;
          sprite_ch.sprite_width  <= s.w;
          sprite_ch.sprite_height <= s.h;
          sprite_ch.drawable      <= s.drawable;
          sprite_ch.cloak         <= s.cloak;
          sprite_ch.blur_enable   <= s.blur_en;
        end else begin
          sprite_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and stall the result side
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          n_errors++;
        end else begin
          xform_res_t e;
          e = expected_results.pop_front();
          if (result_ch.culled !== e.culled) begin
            $error("culled exp %0b got %0b", e.culled, result_ch.culled); n_errors++;
          end
          if (result_ch.screen_x !== e.sx) begin
            $error("screen_x exp %h got %h", e.sx, result_ch.screen_x); n_errors++;
          end
          if (result_ch.screen_y !== e.sy) begin
            $error("screen_y exp %h got %h", e.sy, result_ch.screen_y); n_errors++;
          end
          if (result_ch.xform_a !== e.xa) begin
            $error("xform_a exp %h got %h", e.xa, result_ch.xform_a); n_errors++;
          end
          if (result_ch.xform_b !== e.xb) begin
            $error("xform_b exp %h got %h", e.xb, result_ch.xform_b); n_errors++;
          end
          if (result_ch.xform_c !== e.xc) begin
            $error("xform_c exp %h got %h", e.xc, result_ch.xform_c); n_errors++;
          end
          if (result_ch.xform_d !== e.xd) begin
            $error("xform_d exp %h got %h", e.xd, result_ch.xform_d); n_errors++;
          end
          if (result_ch.blur_u !== e.bu) begin
            $error("blur_u exp %h got %h", e.bu, result_ch.blur_u); n_errors++;
          end
          if (result_ch.blur_v !== e.bv) begin
            $error("blur_v exp %h got %h", e.bv, result_ch.blur_v); n_errors++;
          end
          if (result_ch.alpha !== e.alpha) begin
            $error("alpha exp %h got %h", e.alpha, result_ch.alpha); n_errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        snk_gap <= $urandom_range(1, 13) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst) begin
      if ((sprite_ch.valid && sprite_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || (pending_sprites.size() == 0 &&
          expected_results.size() == 0 && !sprite_ch.valid)) begin
        wdog <= 0;
      end else if (wdog >= WDOG_MAX) begin
        $display("** sprite_cull_and_transform_unit: FAILED **");
        $finish;
      end else begin
        wdog <= wdog + 1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ZOOM:   zoom_q   = val[15:0];
      REG_CAM_X:  cam_x_q  = longint'($signed(val));
      REG_CAM_Y:  cam_y_q  = longint'($signed(val));
      REG_CVEL_X: cvel_x_q = longint'($signed(val));
      REG_CVEL_Y: cvel_y_q = longint'($signed(val));
      REG_HALF_W: half_w_q = val[13:0];
      REG_HALF_H: half_h_q = val[13:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_sprites.size() > 0 || expected_results.size() > 0 || sprite_ch.valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Append one sprite to the driver's queue
  task automatic enqueue_sprite(sprite_t s);
    pending_sprites = {pending_sprites, s};
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8000000) - 4000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic sprite_t rnd_sprite();
    sprite_t s;
    int ang;
    // Mostly on-screen sprites so the transform path gets exercised
    if ($urandom_range(0, 3) != 0) begin
      s.pos_x = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      s.pos_y = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      s.vel_x = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      s.vel_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end else begin
      s.pos_x = rnd_word(); s.pos_y = rnd_word();
      s.vel_x = rnd_word(); s.vel_y = rnd_word();
    end
    s.parallax = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
    ang = $urandom_range(0, 3);
    if (ang == 0) begin
      s.unit_x = 16'($urandom); s.unit_y = 16'($urandom);
    end else begin
      s.unit_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      s.unit_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    end
    s.w = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    s.h = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    s.drawable = ($urandom_range(0, 7) != 0);
    s.cloak    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    s.blur_en  = $urandom_range(0, 1);
    return s;
  endfunction

  task automatic queue_directed();
    sprite_t s;
    s = '{32'sd0, 32'sd0, 32'sd4096, -32'sd4096, 16'd4096, 16'sd16384, 16'sd0,
          16'd1024, 16'd512, 1'b1, 16'd0, 1'b1};
    enqueue_sprite(s);
    s.drawable = 1'b0; enqueue_sprite(s);
    s.drawable = 1'b1; s.w = 16'd0; enqueue_sprite(s);
    s.vel_x = -32'sd4096; enqueue_sprite(s);
    s.vel_x = 32'sd0; s.vel_y = 32'sd0; s.h = 16'd0; enqueue_sprite(s);
    s.w = 16'hFFFF; s.h = 16'hFFFF; s.cloak = 16'hFFFF; enqueue_sprite(s);
    s.cloak = 16'd32768; s.unit_x = 16'sh8000; s.unit_y = 16'sh7FFF;
    enqueue_sprite(s);
    s.unit_x = -16'sd16384; s.unit_y = 16'sd16384; s.blur_en = 1'b0;
    enqueue_sprite(s);
    s.pos_x = 32'sh7FFF_FFFF; s.pos_y = 32'sh8000_0000; enqueue_sprite(s);
    s.pos_x = 32'sh8000_0000; s.pos_y = 32'sh7FFF_FFFF; s.parallax = 16'hFFFF;
    enqueue_sprite(s);
    s.pos_x = 32'sd0; s.pos_y = 32'sd0; s.vel_x = 32'sh7FFF_FFFF;
    s.vel_y = 32'sh8000_0000; s.blur_en = 1'b1; s.w = 16'd16; s.h = 16'd16;
    enqueue_sprite(s);
    // Just past each screen edge at default zoom, then one on the +y edge
    s = '{32'sd980 <<< 12, 32'sd0, 32'sd0, 32'sd0, 16'd0, 16'sd16384, 16'sd0,
          16'd160, 16'd160, 1'b1, 16'd100, 1'b0};
    enqueue_sprite(s);
    s.pos_x = -(32'sd980 <<< 12); enqueue_sprite(s);
    s.pos_x = 32'sd0; s.pos_y = 32'sd560 <<< 12; enqueue_sprite(s);
    s.pos_y = -(32'sd560 <<< 12); enqueue_sprite(s);
    s.pos_y = 32'sd540 <<< 12; enqueue_sprite(s);
  endtask

  initial begin
    sprite_ch.valid = 1'b0;
    sprite_ch.pos_x = '0; sprite_ch.pos_y = '0;
    sprite_ch.vel_x = '0; sprite_ch.vel_y = '0;
    sprite_ch.parallax = '0; sprite_ch.unit_x = '0; sprite_ch.unit_y = '0;
    sprite_ch.sprite_width = '0; sprite_ch.sprite_height = '0;
    sprite_ch.drawable = 1'b0; sprite_ch.cloak = '0; sprite_ch.blur_enable = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    zoom_q = 16'd4096; cam_x_q = 0; cam_y_q = 0; cvel_x_q = 0; cvel_y_q = 0;
    half_w_q = 960; half_h_q = 540;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_directed();
    drain();

    // Phases through register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_ZOOM, 32'd0);
          write_reg(REG_HALF_W, 32'd1);
          write_reg(REG_HALF_H, 32'd1);
        end
        1: begin
          write_reg(REG_ZOOM, 32'hFFFF);
          write_reg(REG_CAM_X, 32'h7FFF_FFFF);
          write_reg(REG_CAM_Y, 32'h8000_0000);
          write_reg(REG_CVEL_X, 32'h8000_0000);
          write_reg(REG_CVEL_Y, 32'h7FFF_FFFF);
          write_reg(REG_HALF_W, 32'd8192);
          write_reg(REG_HALF_H, 32'd8192);
        end
        2: begin
          write_reg(REG_ZOOM, 32'd2048);
          write_reg(REG_CAM_X, 32'h0010_0000);
          write_reg(REG_CAM_Y, 32'hFFF0_0000);
          write_reg(REG_CVEL_X, 32'h0000_4000);
          write_reg(REG_CVEL_Y, 32'hFFFF_C000);
          write_reg(REG_HALF_W, 32'd0);
          write_reg(REG_HALF_H, 32'd16383);
        end
        default: begin
          write_reg(REG_ZOOM, $urandom_range(0, 16384));
          write_reg(REG_CAM_X, $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
          write_reg(REG_CAM_Y, $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
          write_reg(REG_CVEL_X, $urandom);
          write_reg(REG_CVEL_Y, $urandom);
          write_reg(REG_HALF_W, $urandom_range(1, 8192));
          write_reg(REG_HALF_H, $urandom_range(1, 8192));
        end
      endcase
      if (ph == 5) idle_on = 1'b0;
      for (int i = 0; i < N_RANDOM / 6; i++) enqueue_sprite(rnd_sprite());
      drain();
    end

    if (n_errors == 0) begin
      $display("** sprite_cull_and_transform_unit: PASSED **");
    end else begin
      $display("** sprite_cull_and_transform_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
design/scat_pkg.sv
design/scat_sprite_if.sv
design/scat_result_if.sv
design/scat_cfg_if.sv
design/scat_front.sv
design/scat_fifo.sv
design/scat_div.sv
design/scat_back.sv
design/sprite_cull_and_transform_unit.sv
dv/tb_sprite_cull_and_transform_unit.sv
